/* src/i2crts_pkg.sv */
// shared types and codes for the i2c register transaction sequencer
package i2crts_pkg;

  // event codes carried in s_axis_tuser
  localparam logic [2:0] OP_BEGIN     = 3'd0;
  localparam logic [2:0] OP_ARB_LOST  = 3'd1;
  localparam logic [2:0] OP_NACK      = 3'd2;
  localparam logic [2:0] OP_STOP_SEEN = 3'd3;
  localparam logic [2:0] OP_RX_BYTE   = 3'd4;
  localparam logic [2:0] OP_TX_READY  = 3'd5;
  localparam logic [2:0] OP_START_ACK = 3'd6;

  // transaction modes
  localparam logic [2:0] MODE_WR_REG8  = 3'd0;
  localparam logic [2:0] MODE_WR_REG16 = 3'd1;
  localparam logic [2:0] MODE_WR_RAW   = 3'd2;
  localparam logic [2:0] MODE_RD_REG8  = 3'd3;
  localparam logic [2:0] MODE_RD_REG16 = 3'd4;
  localparam logic [2:0] MODE_RD_RAW   = 3'd5;

  // completion status
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ERR  = 2'd1;
  localparam logic [1:0] ST_BUSY = 2'd2;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_W_HI      = 4'd1,
    PH_W_LO      = 4'd2,
    PH_W_DATA    = 4'd3,
    PH_R_HI      = 4'd4,
    PH_R_LO      = 4'd5,
    PH_R_RESTART = 4'd6,
    PH_R_DATA    = 4'd7,
    PH_R_STOP    = 4'd8,
    PH_STOPPING  = 4'd9
  } phase_e;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [2:0]  mode;
    logic [7:0]  slave_addr;
    logic [15:0] sub_addr;
    logic [8:0]  length;
    logic [7:0]  data_byte;
    logic        bus_blocked;
  } item_t;

  typedef struct packed {
    logic        start_request;
    logic        start_as_reader;
    logic [6:0]  bus_addr;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        rx_valid;
    logic [7:0]  rx_byte;
    logic        stop_request;
    logic        done_res;
    logic [1:0]  status;
  } result_t;

endpackage

/* src/i2crts_in_reg.sv */
// input register stage: holds one accepted event for the sequencer core
module i2crts_in_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  i2crts_pkg::item_t    in_item_i,
  input  logic                 advance_i,
  output logic                 valid_o,
  output i2crts_pkg::item_t    item_o
);

  logic              valid_q, valid_d;
  i2crts_pkg::item_t item_q;

  // room when empty or when the held event moves on this cycle
  assign in_ready_o = !valid_q || advance_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // control flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* src/i2crts_core.sv */
// sequencer state and combinational step logic
module i2crts_core #(
  parameter int MAX_LENGTH = 256
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_en_i,
  input  i2crts_pkg::item_t    item_i,
  output i2crts_pkg::result_t  result_o
);

  localparam int RemW = $clog2(MAX_LENGTH + 1);
  localparam logic [16:0] MaxLen = 17'(MAX_LENGTH);

  i2crts_pkg::phase_e phase_q, phase_d;
  logic [RemW-1:0]    rem_q, rem_d;
  logic [15:0]        reg_q, reg_d;
  logic               is_read_q, is_read_d;
  logic               pend_q, pend_d;
  logic [1:0]         err_q, err_d;
  logic [6:0]         bus_q, bus_d;

  logic [16:0] rem_ext;
  logic [16:0] len_ext;
  logic [16:0] len_sat;
  logic        idle;
  logic        rx_ok;
  logic        mode_ok;

  assign rem_ext = 17'(rem_q);
  assign len_ext = {8'd0, item_i.length};
  assign len_sat = (len_ext > MaxLen) ? MaxLen : len_ext;
  assign idle    = (phase_q == i2crts_pkg::PH_IDLE);
  assign mode_ok = (item_i.mode <= i2crts_pkg::MODE_RD_RAW);
  // a received byte counts only in a read's data, stop and stopping phases while bytes remain
  assign rx_ok   = is_read_q && (rem_ext != 17'd0) &&
                   (phase_q inside {i2crts_pkg::PH_R_DATA, i2crts_pkg::PH_R_STOP,
                                    i2crts_pkg::PH_STOPPING});

  // next state
  always_comb begin
    phase_d   = phase_q;
    rem_d     = rem_q;
    reg_d     = reg_q;
    is_read_d = is_read_q;
    pend_d    = pend_q;
    err_d     = err_q;
    bus_d     = bus_q;
    if (item_i.opcode == i2crts_pkg::OP_BEGIN) begin
      if (!item_i.bus_blocked && idle && mode_ok) begin
        rem_d     = len_sat[RemW-1:0];
        reg_d     = (item_i.mode inside {i2crts_pkg::MODE_WR_REG8, i2crts_pkg::MODE_RD_REG8})
                    ? {8'd0, item_i.sub_addr[7:0]} : item_i.sub_addr;
        is_read_d = (item_i.mode >= i2crts_pkg::MODE_RD_REG8);
        err_d     = i2crts_pkg::ST_OK;
        bus_d     = item_i.slave_addr[7:1];
        pend_d    = 1'b1;
        case (item_i.mode)
          i2crts_pkg::MODE_WR_REG8:  phase_d = i2crts_pkg::PH_W_LO;
          i2crts_pkg::MODE_WR_REG16: phase_d = i2crts_pkg::PH_W_HI;
          i2crts_pkg::MODE_WR_RAW:   phase_d = i2crts_pkg::PH_W_DATA;
          i2crts_pkg::MODE_RD_REG8:  phase_d = i2crts_pkg::PH_R_LO;
          i2crts_pkg::MODE_RD_REG16: phase_d = i2crts_pkg::PH_R_HI;
          default: phase_d = (len_sat > 17'd1) ? i2crts_pkg::PH_R_DATA
                                               : i2crts_pkg::PH_R_STOP;
        endcase
      end
    end else if (!idle) begin
      case (item_i.opcode)
        i2crts_pkg::OP_ARB_LOST: begin
          err_d   = i2crts_pkg::ST_ERR;
          phase_d = i2crts_pkg::PH_IDLE;
          pend_d  = 1'b0;
        end
        i2crts_pkg::OP_NACK: begin
          err_d   = i2crts_pkg::ST_ERR;
          phase_d = i2crts_pkg::PH_STOPPING;
        end
        i2crts_pkg::OP_STOP_SEEN: begin
          phase_d = i2crts_pkg::PH_IDLE;
          pend_d  = 1'b0;
        end
        i2crts_pkg::OP_RX_BYTE: begin
          if (rx_ok) begin
            rem_d = rem_q - RemW'(1);
            // second to last byte: stop now, or after the start is acknowledged
            if (phase_q == i2crts_pkg::PH_R_DATA && rem_ext == 17'd2) begin
              phase_d = pend_q ? i2crts_pkg::PH_R_STOP : i2crts_pkg::PH_STOPPING;
            end
          end
        end
        i2crts_pkg::OP_TX_READY: begin
          case (phase_q)
            i2crts_pkg::PH_W_HI: phase_d = i2crts_pkg::PH_W_LO;
            i2crts_pkg::PH_W_LO: phase_d = i2crts_pkg::PH_W_DATA;
            i2crts_pkg::PH_W_DATA: begin
              if (rem_ext != 17'd0) begin
                rem_d = rem_q - RemW'(1);
              end else begin
                phase_d = i2crts_pkg::PH_STOPPING;
              end
            end
            i2crts_pkg::PH_R_HI: phase_d = i2crts_pkg::PH_R_LO;
            i2crts_pkg::PH_R_LO: phase_d = i2crts_pkg::PH_R_RESTART;
            i2crts_pkg::PH_R_RESTART: begin
              pend_d  = 1'b1;
              phase_d = (rem_ext > 17'd1) ? i2crts_pkg::PH_R_DATA : i2crts_pkg::PH_R_STOP;
            end
            default: ;
          endcase
        end
        i2crts_pkg::OP_START_ACK: begin
          pend_d = 1'b0;
          if (phase_q == i2crts_pkg::PH_R_STOP) begin
            phase_d = i2crts_pkg::PH_STOPPING;
          end
        end
        default: ;
      endcase
    end
  end

  // step outputs
  always_comb begin
    result_o = '0;
    if (item_i.opcode == i2crts_pkg::OP_BEGIN) begin
      if (item_i.bus_blocked || !idle) begin
        result_o.done_res = 1'b1;
        result_o.status   = i2crts_pkg::ST_BUSY;
      end else if (!mode_ok) begin
        result_o.done_res = 1'b1;
        result_o.status   = i2crts_pkg::ST_ERR;
      end else begin
        result_o.start_request   = 1'b1;
        result_o.start_as_reader = (item_i.mode == i2crts_pkg::MODE_RD_RAW);
        result_o.bus_addr        = item_i.slave_addr[7:1];
      end
    end else if (!idle) begin
      case (item_i.opcode)
        i2crts_pkg::OP_ARB_LOST: begin
          result_o.done_res = 1'b1;
          result_o.status   = i2crts_pkg::ST_ERR;
        end
        i2crts_pkg::OP_NACK: begin
          result_o.stop_request = 1'b1;
        end
        i2crts_pkg::OP_STOP_SEEN: begin
          result_o.done_res = 1'b1;
          result_o.status   = (is_read_q && rem_ext != 17'd0) ? i2crts_pkg::ST_ERR : err_q;
        end
        i2crts_pkg::OP_RX_BYTE: begin
          if (rx_ok) begin
            result_o.rx_valid = 1'b1;
            result_o.rx_byte  = item_i.data_byte;
            if (phase_q == i2crts_pkg::PH_R_DATA && rem_ext == 17'd2 && !pend_q) begin
              result_o.stop_request = 1'b1;
            end
          end
        end
        i2crts_pkg::OP_TX_READY: begin
          case (phase_q)
            i2crts_pkg::PH_W_HI, i2crts_pkg::PH_R_HI: begin
              result_o.tx_valid = 1'b1;
              result_o.tx_byte  = reg_q[15:8];
            end
            i2crts_pkg::PH_W_LO, i2crts_pkg::PH_R_LO: begin
              result_o.tx_valid = 1'b1;
              result_o.tx_byte  = reg_q[7:0];
            end
            i2crts_pkg::PH_W_DATA: begin
              if (rem_ext != 17'd0) begin
                result_o.tx_valid = 1'b1;
                result_o.tx_byte  = item_i.data_byte;
              end else begin
                result_o.stop_request = 1'b1;
              end
            end
            i2crts_pkg::PH_R_RESTART: begin
              result_o.start_request   = 1'b1;
              result_o.start_as_reader = 1'b1;
              result_o.bus_addr        = bus_q;
            end
            default: ;
          endcase
        end
        i2crts_pkg::OP_START_ACK: begin
          if (phase_q == i2crts_pkg::PH_R_STOP) begin
            result_o.stop_request = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= i2crts_pkg::PH_IDLE;
      rem_q     <= '0;
      reg_q     <= '0;
      is_read_q <= 1'b0;
      pend_q    <= 1'b0;
      err_q     <= i2crts_pkg::ST_OK;
      bus_q     <= '0;
    end else if (step_en_i) begin
      phase_q   <= phase_d;
      rem_q     <= rem_d;
      reg_q     <= reg_d;
      is_read_q <= is_read_d;
      pend_q    <= pend_d;
      err_q     <= err_d;
      bus_q     <= bus_d;
    end
  end

  // no start can be outstanding while idle
  a_idle_no_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == i2crts_pkg::PH_IDLE |-> !pend_q)
    else $error("start pending while idle");

  // read phases belong to read transactions only
  a_read_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == i2crts_pkg::PH_R_HI || phase_q == i2crts_pkg::PH_R_LO ||
     phase_q == i2crts_pkg::PH_R_RESTART || phase_q == i2crts_pkg::PH_R_DATA ||
     phase_q == i2crts_pkg::PH_R_STOP) |-> is_read_q)
    else $error("read phase without read transaction");

  // byte count never exceeds the saturation limit
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rem_ext <= MaxLen)
    else $error("remaining count above limit");

  // state moves only on a processed event
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !step_en_i |=> $stable(phase_q) && $stable(rem_q) && $stable(pend_q))
    else $error("state changed without an event");

endmodule

/* src/i2c_register_transaction_sequencer.sv */
// top level of the i2c register transaction sequencer
//
// Usage: the block sits above a byte-level i2c master. Every bus event or
// begin request enters on the s_axis channel (event code in s_axis_tuser,
// arguments in s_axis_tdata) and produces exactly one result on m_axis:
// start/restart requests, a byte to transmit, a received byte to store,
// a stop request and the done flag with its status.
// Timing: the event passes the input register and then the result register,
// and a stall on m_axis holds it in the input register.
// Throughput: one event per cycle while m_axis_tready does not hold back the
// result register; the step logic reads the sequencer state and the
// registered event and updates both.
// Reset clears the sequencer to idle, empties both register stages and
// drops m_axis_tvalid. When the receiver holds m_axis_tready low, the
// result stays put, the event behind it waits in the input register and
// s_axis_tready falls only once both stages are full.
module i2c_register_transaction_sequencer #(
  parameter int MAX_LENGTH = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tuser: opcode[2:0]
  input  logic [2:0]  s_axis_tuser,
  // tdata: mode[2:0], slave_addr[10:3], sub_addr[26:11], length[35:27],
  //        data_byte[43:36], bus_blocked[44], ignored[47:45]
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: start_request[0], start_as_reader[1], bus_addr[8:2], tx_valid[9],
  //        tx_byte[17:10], rx_valid[18], rx_byte[26:19], stop_request[27],
  //        done_res[28], status[30:29], zero fill[31]
  output logic [31:0] m_axis_tdata
);

  i2crts_pkg::item_t   in_item;
  i2crts_pkg::item_t   held_item;
  i2crts_pkg::result_t step_res;
  i2crts_pkg::result_t res_q;
  logic                held_valid;
  logic                advance;
  logic                step_en;
  logic                out_valid_q, out_valid_d;

  // unpack the incoming transaction
  assign in_item.opcode      = s_axis_tuser;
  assign in_item.mode        = s_axis_tdata[2:0];
  assign in_item.slave_addr  = s_axis_tdata[10:3];
  assign in_item.sub_addr    = s_axis_tdata[26:11];
  assign in_item.length      = s_axis_tdata[35:27];
  assign in_item.data_byte   = s_axis_tdata[43:36];
  assign in_item.bus_blocked = s_axis_tdata[44];

  // the result register frees up when empty or when taken
  assign advance = !out_valid_q || m_axis_tready;
  assign step_en = held_valid && advance;

  i2crts_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_item_i  (in_item),
    .advance_i  (advance),
    .valid_o    (held_valid),
    .item_o     (held_item)
  );

  i2crts_core #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .item_i    (held_item),
    .result_o  (step_res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = held_valid;
    end
  end

  // result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (step_en) begin
      res_q <= step_res;
    end
  end

  // pack the outgoing transaction
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, res_q.status, res_q.done_res, res_q.stop_request,
                          res_q.rx_byte, res_q.rx_valid, res_q.tx_byte, res_q.tx_valid,
                          res_q.bus_addr, res_q.start_as_reader, res_q.start_request};

endmodule
